### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by bez_drain
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/bez_pkg.sv
// ----------------------------------------------------------------------------
// bez_pkg
// Widths, codes and word types of the cubic Bezier point and split block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bez_pkg;

   // coordinate and parameter formats
   localparam int COORD_WIDTH = 24;
   localparam int T_FRAC_BITS = 16;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;

   // configuration port
   localparam int NUM_REGS       = 8;
   localparam int REG_IDX_WIDTH  = $clog2(NUM_REGS);
   localparam int CSR_DATA_WIDTH = (COORD_WIDTH > 32) ? 64 : 32;
   localparam int REG_ADDR_LSB   = (CSR_DATA_WIDTH == 64) ? 3 : 2;
   localparam int CSR_ADDR_WIDTH = REG_ADDR_LSB + REG_IDX_WIDTH;

   // commands
   localparam logic CMD_EVAL  = 1'b0;
   localparam logic CMD_SPLIT = 1'b1;

   // positions in a split sequence
   localparam int IDX_WIDTH = 3;
   localparam logic [IDX_WIDTH-1:0] IDX_P0    = 3'd0;
   localparam logic [IDX_WIDTH-1:0] IDX_L1    = 3'd1;
   localparam logic [IDX_WIDTH-1:0] IDX_L2    = 3'd2;
   localparam logic [IDX_WIDTH-1:0] IDX_SPLIT = 3'd3;
   localparam logic [IDX_WIDTH-1:0] IDX_R1    = 3'd4;
   localparam logic [IDX_WIDTH-1:0] IDX_R2    = 3'd5;
   localparam logic [IDX_WIDTH-1:0] IDX_P3    = 3'd6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic        [T_WIDTH-1:0]     t_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // input word
   typedef struct packed {
      logic  command;
      t_type t;
   } req_type;

   // result word
   typedef struct packed {
      coord_type             x;
      coord_type             y;
      logic [IDX_WIDTH-1:0]  index;
      logic                  last;
   } rsp_type;

   // computed points of one item handed to the output stage
   typedef struct packed {
      logic      command;
      point_type a;
      point_type c;
      point_type d;
      point_type e;
      point_type s;
   } item_type;

endpackage

### rtl/bez_lerp_cell.sv
// ----------------------------------------------------------------------------
// bez_lerp_cell
// One registered interpolation cell: y = a + round((b - a) * t)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bez_lerp_cell (
   input  logic               clock,
   input  logic               en,
   input  bez_pkg::coord_type a,
   input  bez_pkg::coord_type b,
   input  bez_pkg::t_type     t,
   output bez_pkg::coord_type y_ff
);
   import bez_pkg::*;

   localparam int PROD_WIDTH = COORD_WIDTH + 1 + T_WIDTH;
   localparam logic [PROD_WIDTH-1:0] HALF = PROD_WIDTH'(1) << (T_FRAC_BITS - 1);

   logic signed [COORD_WIDTH:0]   diff;
   logic                          neg;
   logic        [COORD_WIDTH:0]   mag;
   logic        [PROD_WIDTH-1:0]  prod;
   logic        [PROD_WIDTH-1:0]  rnd;
   logic        [COORD_WIDTH+1:0] q;
   logic signed [COORD_WIDTH+1:0] a_ext;
   logic signed [COORD_WIDTH+1:0] sum;
   coord_type                     y_in;

   // difference magnitude times t, rounded half away from zero
   always_comb begin
      diff  = (COORD_WIDTH+1)'(b) - (COORD_WIDTH+1)'(a);
      neg   = diff[COORD_WIDTH];
      mag   = neg ? (COORD_WIDTH+1)'(-diff) : (COORD_WIDTH+1)'(diff);
      prod  = PROD_WIDTH'(mag) * PROD_WIDTH'(t);
      rnd   = prod + HALF;
      q     = rnd[PROD_WIDTH-1 -: (COORD_WIDTH+2)];
      a_ext = (COORD_WIDTH+2)'(a);
      sum   = neg ? (a_ext - $signed(q)) : (a_ext + $signed(q));
      y_in  = sum[COORD_WIDTH-1:0];
   end

   // result register, moves with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

endmodule

### rtl/bez_drain.sv
// ----------------------------------------------------------------------------
// bez_drain
// Output stage: holds one item and sends one or seven result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bez_drain (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  bez_pkg::item_type   load_item,
   input  bez_pkg::point_type  p0,
   input  bez_pkg::point_type  p3,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bez_pkg::rsp_type    rsp_data
);
   import bez_pkg::*;

   logic                 valid_ff, valid_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   item_type             item_ff;
   logic                 take;
   logic                 last;
   logic                 load;
   logic                 is_eval;
   point_type            pt;

   // handshake and end of item
   assign is_eval = (item_ff.command == CMD_EVAL);
   assign take    = valid_ff && !rsp_stall;
   assign last    = is_eval || (idx_ff == IDX_P3);
   assign load_ok = !valid_ff || (take && last);
   assign load    = load_ok && load_valid;

   always_comb begin
      valid_in = load_ok ? load_valid : valid_ff;
      if (load_ok) begin
         idx_in = IDX_P0;
      end else if (take) begin
         idx_in = idx_ff + IDX_WIDTH'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= IDX_P0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   // select the point for the current position
   always_comb begin
      if (item_ff.command == CMD_EVAL) begin
         pt = item_ff.s;
      end else begin
         case (idx_ff)
            IDX_P0:    pt = p0;
            IDX_L1:    pt = item_ff.a;
            IDX_L2:    pt = item_ff.d;
            IDX_SPLIT: pt = item_ff.s;
            IDX_R1:    pt = item_ff.e;
            IDX_R2:    pt = item_ff.c;
            default:   pt = p3;
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data.x     = pt.x;
   assign rsp_data.y     = pt.y;
   assign rsp_data.index = (item_ff.command == CMD_EVAL) ? IDX_P0 : idx_ff;
   assign rsp_data.last  = last;

   // checks
   `ASSERT_CLK(a_idx_range, clock, reset, valid_ff |-> (idx_ff <= IDX_P3))
   `ASSERT_CLK(a_split_continues, clock, reset, (take && !last) |=> valid_ff)
   `ASSERT_CLK(a_eval_single, clock, reset, (valid_ff && is_eval) |-> (idx_ff == IDX_P0))
   `ASSERT_CLK(a_stall_holds_idx, clock, reset, (valid_ff && rsp_stall) |=> $stable(idx_ff))

endmodule

### rtl/cubic_bezier_point_and_split.sv
// A word passes the three cell rows, then the output stage presents its first result.
// Throughput: one eval word per cycle when not stalled; a split word sends seven results.
// Three rows of interpolation cells (three, two and one per axis) form the pipeline.
// Reset (synchronous) clears all control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_split
// De Casteljau point evaluation and curve split over a chain of lerp cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bezier_point_and_split (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bez_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bez_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [bez_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [bez_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output logic [bez_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import bez_pkg::*;

   localparam t_type T_ONE = t_type'(1) << T_FRAC_BITS;

   coord_type              regs_ff [NUM_REGS];
   logic [REG_IDX_WIDTH-1:0] reg_idx;
   logic                   csr_wr;

   logic      en;
   logic      load_ok;
   t_type     t_sat;

   logic      v1_ff, v2_ff, v3_ff;
   logic      cmd1_ff, cmd2_ff, cmd3_ff;
   t_type     t1_ff, t2_ff;

   coord_type pa [2];
   coord_type pb [2];
   coord_type pc [2];
   coord_type pd [2];
   coord_type a1 [2];
   coord_type b1 [2];
   coord_type c1 [2];
   coord_type d2 [2];
   coord_type e2 [2];
   coord_type s3 [2];
   coord_type a2_ff [2];
   coord_type c2_ff [2];
   coord_type a3_ff [2];
   coord_type c3_ff [2];
   coord_type d3_ff [2];
   coord_type e3_ff [2];

   item_type  item;
   point_type p0;
   point_type p3;

   // register file
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:REG_ADDR_LSB];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CSR_DATA_WIDTH'(regs_ff[reg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         regs_ff[reg_idx] <= csr_pwdata[COORD_WIDTH-1:0];
      end
   end

   // pipeline moves unless the last row is full and the output stage is busy
   assign en        = !v3_ff || load_ok;
   assign req_stall = !en;
   assign t_sat     = (req_data.t > T_ONE) ? T_ONE : req_data.t;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // word fields riding along the chain
   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= t_sat;
         cmd1_ff <= req_data.command;
         t2_ff   <= t1_ff;
         cmd2_ff <= cmd1_ff;
         cmd3_ff <= cmd2_ff;
         for (int k = 0; k < 2; k++) begin
            a2_ff[k] <= a1[k];
            c2_ff[k] <= c1[k];
            a3_ff[k] <= a2_ff[k];
            c3_ff[k] <= c2_ff[k];
            d3_ff[k] <= d2[k];
            e3_ff[k] <= e2[k];
         end
      end
   end

   // rows of cells, one column per axis
   for (genvar k = 0; k < 2; k++) begin : g_axis
      assign pa[k] = regs_ff[k];
      assign pb[k] = regs_ff[2 + k];
      assign pc[k] = regs_ff[4 + k];
      assign pd[k] = regs_ff[6 + k];

      bez_lerp_cell u_a (.clock(clock), .en(en), .a(pa[k]), .b(pb[k]), .t(t_sat), .y_ff(a1[k]));
      bez_lerp_cell u_b (.clock(clock), .en(en), .a(pb[k]), .b(pc[k]), .t(t_sat), .y_ff(b1[k]));
      bez_lerp_cell u_c (.clock(clock), .en(en), .a(pc[k]), .b(pd[k]), .t(t_sat), .y_ff(c1[k]));

      bez_lerp_cell u_d (.clock(clock), .en(en), .a(a1[k]), .b(b1[k]), .t(t1_ff), .y_ff(d2[k]));
      bez_lerp_cell u_e (.clock(clock), .en(en), .a(b1[k]), .b(c1[k]), .t(t1_ff), .y_ff(e2[k]));

      bez_lerp_cell u_s (.clock(clock), .en(en), .a(d2[k]), .b(e2[k]), .t(t2_ff), .y_ff(s3[k]));
   end

   // hand the finished item to the output stage
   assign item.command = cmd3_ff;
   assign item.a       = '{x: a3_ff[0], y: a3_ff[1]};
   assign item.c       = '{x: c3_ff[0], y: c3_ff[1]};
   assign item.d       = '{x: d3_ff[0], y: d3_ff[1]};
   assign item.e       = '{x: e3_ff[0], y: e3_ff[1]};
   assign item.s       = '{x: s3[0], y: s3[1]};
   assign p0           = '{x: regs_ff[0], y: regs_ff[1]};
   assign p3           = '{x: regs_ff[6], y: regs_ff[7]};

   bez_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load_valid (v3_ff),
      .load_item  (item),
      .p0         (p0),
      .p3         (p3),
      .load_ok    (load_ok),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
